>>> sv/resonant_filter_coefficients_macros.svh
// Assertion macros for the resonant filter coefficient block.
// Used by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef RESONANT_FILTER_COEFFICIENTS_MACROS_SVH
`define RESONANT_FILTER_COEFFICIENTS_MACROS_SVH

// Clocked check, masked while reset is asserted
`define RFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset
`define RFC_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/rfc_pkg.sv
// Shared types, constants and constant tables for the resonant filter coefficients.
// No dependencies; imported by rfc_muldiv and resonant_filter_coefficients.
package rfc_pkg;

    localparam int COEF_FRAC_BITS_DEF = 24;
    localparam int DAMP_DEPTH         = 128;
    localparam int MD_W               = 64;

    localparam logic [31:0] DAMP_STEP_Q32  = 32'd4203246592;
    localparam logic [18:0] TWO_PI_Q16     = 19'd411775;
    localparam logic [17:0] MIX_RATE_RESET = 18'd44100;

    localparam logic [25:0] GAIN_MAX    = 26'd33554432;
    localparam logic [26:0] FB1_POS_MAX = 27'd67108863;
    localparam logic [26:0] FB1_NEG_MAG = 27'd67108864;
    localparam logic [25:0] FB2_NEG_MAG = 26'd33554432;

    // shared unit operations
    typedef enum logic {MD_MUL, MD_DIV} md_op_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_stat_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_TWOPI, ST_RDIV, ST_TMUL,
        ST_RMUL, ST_RECIP, ST_B0, ST_B1, ST_FINISH
    } rfc_state_t;

    typedef logic [16:0] semi_tab_t [12];
    typedef logic [16:0] quarter_tab_t [4];
    typedef logic [23:0] freq_tab_t [48];
    typedef logic [16:0] damp_tab_t [DAMP_DEPTH];

    localparam semi_tab_t SEMITONE_Q16 = '{
        17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
        17'd92682, 17'd98193, 17'd104032, 17'd110217, 17'd116772, 17'd123715
    };
    localparam quarter_tab_t QUARTER_Q16 = '{17'd65536, 17'd66489, 17'd67456, 17'd68438};

    // 110 * 2^(k/48) in Q8.16 for k = 0..47
    function automatic freq_tab_t build_freq_tab();
        freq_tab_t   tab;
        logic [33:0] prod;
        logic [16:0] v;
        for (int i = 0; i < 48; i++) begin
            prod   = 34'(SEMITONE_Q16[i / 4]) * 34'(QUARTER_Q16[i % 4]) + 34'd32768;
            v      = prod[32:16];
            tab[i] = 24'(24'(v) * 24'd110);
        end
        return tab;
    endfunction

    // damping factor per resonance step, Q16, truncated Q32 chain
    function automatic damp_tab_t build_damp_tab();
        damp_tab_t   tab;
        logic [63:0] acc;
        logic [63:0] rnd;
        acc = 64'h1_0000_0000;
        for (int i = 0; i < DAMP_DEPTH; i++) begin
            rnd    = acc + 64'd32768;
            tab[i] = rnd[32:16];
            acc    = (acc * 64'(DAMP_STEP_Q32)) >> 32;
        end
        return tab;
    endfunction

    localparam freq_tab_t FREQ_BASE_TAB = build_freq_tab();
    localparam damp_tab_t DAMP_TAB      = build_damp_tab();

    typedef struct packed {
        logic [2:0] oct;
        logic [5:0] step;
    } oct_split_t;

    // n / 48 and n % 48 for n below 288
    function automatic oct_split_t split_octave(input logic [8:0] n);
        oct_split_t res;
        logic [8:0] rem;
        logic [2:0] oct;
        rem = n;
        oct = '0;
        for (int k = 0; k < 5; k++) begin
            if (rem >= 9'd48) begin
                rem = rem - 9'd48;
                oct = oct + 3'd1;
            end
        end
        res.oct  = oct;
        res.step = rem[5:0];
        return res;
    endfunction

endpackage

>>> sv/resonant_filter_coefficients.sv
// Active update: two 64-step divides plus five shift-add multiplies, each one bit per
// cycle on the shared rfc_muldiv unit; a bypassed update goes from ST_PREP straight to
// ST_FINISH without using the unit. One word at a time, in_ready only when idle;
// the next word may start while the previous result waits in the output register.
// Reset: mix rate 44100, filter off, held coefficients zero, no result pending.
`include "resonant_filter_coefficients_macros.svh"

module resonant_filter_coefficients
    import rfc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mix_rate_we,
    input  logic [17:0]        mix_rate_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         cutoff_value,
    input  logic [7:0]         resonance_value,
    input  logic signed [9:0]  envelope_modifier,
    input  logic               new_note,
    input  logic               clear_request,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               filter_enabled,
    output logic [25:0]        gain_coef,
    output logic signed [26:0] feedback_one,
    output logic signed [25:0] feedback_two,
    output logic               clear_history
);

    localparam int SH_PROD = 48 - COEF_FRAC_BITS;
    localparam int SH_GAIN = 32 - COEF_FRAC_BITS;

    rfc_state_t state_reg, state_next;

    logic        launched_reg;
    logic [17:0] mix_rate_reg;

    // input word
    logic [7:0]        cut_in_reg;
    logic [7:0]        res_in_reg;
    logic signed [9:0] mod_in_reg;
    logic              note_reg;
    logic              clr_reg;

    // working values
    logic [6:0]  res_reg;
    logic [17:0] rate_reg;
    logic [33:0] freq_reg;
    logic [47:0] twopif_reg;
    logic [25:0] r_reg;
    logic [25:0] tr_reg;
    logic [33:0] e_reg;
    logic [48:0] recip_reg;

    // pending result
    logic        pend_en_reg;
    logic [25:0] pend_gain_reg;
    logic [26:0] pend_fb1_reg;
    logic [25:0] pend_fb2_reg;
    logic        pend_clr_reg;

    // output / held state
    logic        out_valid_reg;
    logic        en_reg;
    logic [25:0] gain_reg;
    logic [26:0] fb1_reg;
    logic [25:0] fb2_reg;
    logic        clrh_reg;

    md_ctrl_t        md_ctrl;
    md_stat_t        md_stat;
    logic [MD_W-1:0] md_a;
    logic [MD_W-1:0] md_b;
    logic [MD_W-1:0] md_result;

    rfc_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (md_ctrl),
        .a      (md_a),
        .b      (md_b),
        .stat   (md_stat),
        .result (md_result)
    );

    // cutoff scaling and clamps
    logic signed [10:0] mod_ext;
    logic signed [19:0] sprod;
    logic [7:0]         cut_scaled;
    logic [6:0]         res_cl;
    logic               bypass;
    oct_split_t         osplit;
    logic [33:0]        freq_raw;
    logic [17:0]        rate_eff;
    logic [33:0]        freq_lim;

    assign mod_ext  = 11'(mod_in_reg) + 11'sd256;
    assign sprod    = $signed({12'd0, cut_in_reg}) * 20'(mod_ext);
    assign res_cl   = (res_in_reg > 8'd127) ? 7'd127 : res_in_reg[6:0];
    assign osplit   = split_octave(9'(cut_scaled) + 9'd12);
    assign freq_raw = 34'(FREQ_BASE_TAB[osplit.step]) << osplit.oct;
    assign rate_eff = (mix_rate_reg == '0) ? 18'd1 : mix_rate_reg;
    assign freq_lim = {1'b0, rate_eff, 15'd0};
    assign bypass   = (res_cl == '0) && (cut_scaled >= 8'd254);

    always_comb
    begin
        if (sprod < 0)
            cut_scaled = '0;
        else if (sprod[19:8] > 12'd255)
            cut_scaled = 8'd255;
        else
            cut_scaled = sprod[15:8];
    end

    // denominator and signed numerator of b0
    logic [16:0] damp_t;
    logic [35:0] den;
    logic [36:0] num_sum;
    logic        num_neg;
    logic [36:0] num_mag;

    assign damp_t  = DAMP_TAB[res_reg];
    assign den     = 36'(tr_reg) + 36'(damp_t) + 36'(e_reg);
    assign num_sum = 37'(tr_reg) + 37'(damp_t) + 37'(e_reg) + 37'(e_reg);
    assign num_neg = num_sum < 37'd65536;
    assign num_mag = num_neg ? (37'd65536 - num_sum) : (num_sum - 37'd65536);

    // saturation of the results
    logic [MD_W-1:0] prod_sh;
    logic [48:0]     gain_sh;
    logic [26:0]     fb1_sat;
    logic [25:0]     fb2_sat;
    logic [25:0]     gain_sat;

    assign prod_sh = md_result >> SH_PROD;
    assign gain_sh = md_result[48:0] >> SH_GAIN;

    always_comb
    begin
        if (num_neg)
            fb1_sat = (prod_sh > MD_W'(FB1_NEG_MAG)) ? (27'd0 - FB1_NEG_MAG)
                                                      : (27'd0 - prod_sh[26:0]);
        else
            fb1_sat = (prod_sh > MD_W'(FB1_POS_MAX)) ? FB1_POS_MAX : prod_sh[26:0];
        fb2_sat  = (prod_sh > MD_W'(FB2_NEG_MAG)) ? (26'd0 - FB2_NEG_MAG)
                                                   : (26'd0 - prod_sh[25:0]);
        gain_sat = (gain_sh > 49'(GAIN_MAX)) ? GAIN_MAX : gain_sh[25:0];
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and shared unit control
    always_comb
    begin
        state_next = state_reg;
        md_ctrl    = '{start: 1'b0, op: MD_MUL};
        md_a       = '0;
        md_b       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = bypass ? ST_FINISH : ST_TWOPI;
            end
            ST_TWOPI:
            begin
                md_ctrl = '{start: !launched_reg, op: MD_MUL};
                md_a    = MD_W'(freq_reg);
                md_b    = MD_W'(TWO_PI_Q16);
                if (md_stat.done)
                    state_next = ST_RDIV;
            end
            ST_RDIV:
            begin
                md_ctrl = '{start: !launched_reg, op: MD_DIV};
                md_a    = {14'd0, rate_reg, 32'd0};
                md_b    = MD_W'(twopif_reg);
                if (md_stat.done)
                    state_next = ST_TMUL;
            end
            ST_TMUL:
            begin
                md_ctrl = '{start: !launched_reg, op: MD_MUL};
                md_a    = MD_W'(r_reg);
                md_b    = MD_W'(damp_t);
                if (md_stat.done)
                    state_next = ST_RMUL;
            end
            ST_RMUL:
            begin
                md_ctrl = '{start: !launched_reg, op: MD_MUL};
                md_a    = MD_W'(r_reg);
                md_b    = MD_W'(r_reg);
                if (md_stat.done)
                    state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                md_ctrl = '{start: !launched_reg, op: MD_DIV};
                md_a    = MD_W'(1) << 48;
                md_b    = (den == '0) ? MD_W'(1) : MD_W'(den);
                if (md_stat.done)
                    state_next = ST_B0;
            end
            ST_B0:
            begin
                md_ctrl = '{start: !launched_reg, op: MD_MUL};
                md_a    = MD_W'(num_mag);
                md_b    = MD_W'(recip_reg);
                if (md_stat.done)
                    state_next = ST_B1;
            end
            ST_B1:
            begin
                md_ctrl = '{start: !launched_reg, op: MD_MUL};
                md_a    = MD_W'(e_reg);
                md_b    = MD_W'(recip_reg);
                if (md_stat.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launched_reg  <= 1'b0;
            mix_rate_reg  <= MIX_RATE_RESET;
            out_valid_reg <= 1'b0;
            en_reg        <= 1'b0;
            gain_reg      <= '0;
            fb1_reg       <= '0;
            fb2_reg       <= '0;
            clrh_reg      <= 1'b0;
        end
        else
        begin
            if (mix_rate_we)
                mix_rate_reg <= mix_rate_data;

            if (md_ctrl.start)
                launched_reg <= 1'b1;
            else if (md_stat.done)
                launched_reg <= 1'b0;

            // result load, or drain of a taken word
            if (state_reg == ST_FINISH && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                en_reg        <= pend_en_reg;
                gain_reg      <= pend_gain_reg;
                fb1_reg       <= pend_fb1_reg;
                fb2_reg       <= pend_fb2_reg;
                clrh_reg      <= pend_clr_reg;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cut_in_reg <= cutoff_value;
                    res_in_reg <= resonance_value;
                    mod_in_reg <= envelope_modifier;
                    note_reg   <= new_note;
                    clr_reg    <= clear_request;
                end
            end
            ST_PREP:
            begin
                res_reg  <= res_cl;
                rate_reg <= rate_eff;
                freq_reg <= (freq_raw > freq_lim) ? freq_lim : freq_raw;
                // bypass keeps held coefficients
                pend_en_reg   <= note_reg ? 1'b0 : en_reg;
                pend_gain_reg <= gain_reg;
                pend_fb1_reg  <= fb1_reg;
                pend_fb2_reg  <= fb2_reg;
                pend_clr_reg  <= 1'b0;
            end
            ST_TWOPI:
            begin
                if (md_stat.done)
                    twopif_reg <= (md_result[63:16] == '0) ? 48'd1 : md_result[63:16];
            end
            ST_RDIV:
            begin
                if (md_stat.done)
                    r_reg <= md_result[25:0];
            end
            ST_TMUL:
            begin
                if (md_stat.done)
                    tr_reg <= md_result[41:16];
            end
            ST_RMUL:
            begin
                if (md_stat.done)
                    e_reg <= md_result[49:16];
            end
            ST_RECIP:
            begin
                if (md_stat.done)
                begin
                    recip_reg     <= md_result[48:0];
                    pend_gain_reg <= gain_sat;
                end
            end
            ST_B0:
            begin
                if (md_stat.done)
                    pend_fb1_reg <= fb1_sat;
            end
            ST_B1:
            begin
                if (md_stat.done)
                begin
                    pend_fb2_reg <= fb2_sat;
                    pend_en_reg  <= 1'b1;
                    pend_clr_reg <= clr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign filter_enabled = en_reg;
    assign gain_coef      = gain_reg;
    assign feedback_one   = fb1_reg;
    assign feedback_two   = fb2_reg;
    assign clear_history  = clrh_reg;

    // checks
    `RFC_ASSERT(a_start_not_busy, md_ctrl.start |-> !md_stat.busy, "muldiv restarted while busy")
    `RFC_ASSERT(a_idle_unit_free, in_ready |-> (!md_stat.busy && !launched_reg), "idle with unit busy")
    `RFC_ASSERT(a_fb2_nonpos, out_valid |-> (feedback_two[25] || feedback_two == '0), "b1 positive")
    `RFC_ASSERT(a_gain_limit, out_valid |-> (gain_coef <= GAIN_MAX), "a0 above limit")
    `RFC_ASSERT_NR(a_reset_empty, $rose(rst_n) |-> !out_valid, "result pending after reset")

endmodule

>>> sv/rfc_muldiv.sv
// Shared iterative unit: shift-add multiply and restoring divide, one bit per cycle.
// Depends on rfc_pkg (md_ctrl_t, md_stat_t, MD_W).
module rfc_muldiv
    import rfc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  md_ctrl_t        ctrl,
    input  logic [MD_W-1:0] a,
    input  logic [MD_W-1:0] b,
    output md_stat_t        stat,
    output logic [MD_W-1:0] result
);

    localparam int CNT_W = $clog2(MD_W);

    logic             busy_reg;
    logic             done_reg;
    md_op_t           op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MD_W-1:0]  acc_reg;
    logic [MD_W-1:0]  x_reg;
    logic [MD_W-1:0]  y_reg;
    logic [MD_W-1:0]  rem_reg;

    logic [MD_W:0]    rem_sh;
    logic [MD_W:0]    diff;
    logic             q_bit;
    logic [MD_W-1:0]  rem_next;

    // restoring divide step
    assign rem_sh   = {rem_reg, x_reg[MD_W-1]};
    assign diff     = rem_sh - {1'b0, y_reg};
    assign q_bit    = ~diff[MD_W];
    assign rem_next = q_bit ? diff[MD_W-1:0] : rem_sh[MD_W-1:0];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= MD_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= ctrl.op;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (op_reg == MD_MUL)
                begin
                    if (y_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(MD_W - 1))
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            acc_reg <= '0;
            x_reg   <= a;
            y_reg   <= b;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (op_reg == MD_MUL)
            begin
                if (y_reg[0])
                    acc_reg <= acc_reg + x_reg;
                x_reg <= x_reg << 1;
                y_reg <= y_reg >> 1;
            end
            else
            begin
                rem_reg <= rem_next;
                acc_reg <= {acc_reg[MD_W-2:0], q_bit};
                x_reg   <= x_reg << 1;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = acc_reg;

endmodule

>>> sim/tb_resonant_filter_coefficients.sv
// Self-checking bench for resonant_filter_coefficients: directed and random voice updates.
// Depends on rfc_pkg and the block's RTL; predicts coefficients in fixed point locally.
`timescale 1ns / 100ps

module tb_resonant_filter_coefficients;
    import rfc_pkg::*;

    typedef struct packed {
        logic [7:0]        cutoff;
        logic [7:0]        resonance;
        logic signed [9:0] modifier;
        logic              note;
        logic              clr;
    } voice_word_t;

    typedef struct packed {
        logic              enabled;
        logic [25:0]       gain;
        logic signed [26:0] fb1;
        logic signed [25:0] fb2;
        logic              clr_hist;
    } coef_word_t;

    localparam int FRAC = COEF_FRAC_BITS_DEF;

    logic clk;
    logic rst_n;
    logic mix_rate_we;
    logic [17:0] mix_rate_data;
    logic in_valid;
    logic in_ready;
    logic [7:0] cutoff_value;
    logic [7:0] resonance_value;
    logic signed [9:0] envelope_modifier;
    logic new_note;
    logic clear_request;
    logic out_valid;
    logic out_ready;
    logic filter_enabled;
    logic [25:0] gain_coef;
    logic signed [26:0] feedback_one;
    logic signed [25:0] feedback_two;
    logic clear_history;

    voice_word_t pending_words[$];
    coef_word_t  expected_coefs[$];
    int          error_count;
    bit          sender_calm;
    bit          receiver_calm;
    int          hold_cycles;

    // predictor state
    logic [17:0] model_rate;
    logic        model_enabled;
    longint      model_gain;
    longint      model_fb1;
    longint      model_fb2;

    resonant_filter_coefficients i_dut (
        .clk(clk), .rst_n(rst_n),
        .mix_rate_we(mix_rate_we), .mix_rate_data(mix_rate_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cutoff_value(cutoff_value), .resonance_value(resonance_value),
        .envelope_modifier(envelope_modifier), .new_note(new_note),
        .clear_request(clear_request),
        .out_valid(out_valid), .out_ready(out_ready),
        .filter_enabled(filter_enabled), .gain_coef(gain_coef),
        .feedback_one(feedback_one), .feedback_two(feedback_two),
        .clear_history(clear_history)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // (num * recip) >> sh, truncated toward zero, magnitude capped at 2^40
    function automatic longint trunc_product(longint num, longint unsigned recip, int sh);
        longint unsigned mag;
        longint unsigned p;
        mag = (num < 0) ? longint'(-num) : num;
        p = (mag * recip) >> sh;
        if (p > (64'd1 << 40)) p = 64'd1 << 40;
        return (num < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned damping_factor(int res);
        longint unsigned acc;
        acc = 64'd1 << 32;
        for (int i = 0; i < res; i++) acc = (acc * 64'd4203246592) >> 32;
        return (acc + 64'd32768) >> 16;
    endfunction

    function automatic coef_word_t predict_coefs(voice_word_t w);
        coef_word_t o;
        int cut;
        int res;
        int n;
        int oct;
        int stp;
        longint unsigned rate;
        longint unsigned v;
        longint unsigned freq;
        longint unsigned twopif;
        longint unsigned r;
        longint unsigned t;
        longint unsigned recip;
        longint d;
        longint e;
        longint den;
        logic clear_out;
        longint unsigned semi[12];
        longint unsigned quart[4];
        semi = '{65536, 69433, 73562, 77936, 82570, 87480,
                 92682, 98193, 104032, 110217, 116772, 123715};
        quart = '{65536, 66489, 67456, 68438};
        clear_out = 1'b0;
        cut = int'(w.cutoff) * (int'(w.modifier) + 256) / 256;
        if (cut < 0) cut = 0;
        if (cut > 255) cut = 255;
        res = (w.resonance > 127) ? 127 : int'(w.resonance);
        if (res == 0 && cut >= 254)
        begin
            // bypass: keep coefficients
            if (w.note) model_enabled = 1'b0;
        end
        else
        begin
            rate = (model_rate == 0) ? 1 : model_rate;
            n = cut + 12;
            oct = n / 48;
            stp = n % 48;
            v = (semi[stp / 4] * quart[stp % 4] + 64'd32768) >> 16;
            freq = (64'd110 * v) << oct;
            if (freq > (rate << 15)) freq = rate << 15;
            twopif = (freq * 64'd411775) >> 16;
            if (twopif == 0) twopif = 1;
            r = (rate << 32) / twopif;
            t = damping_factor(res);
            d = longint'((t * r) >> 16) + longint'(t) - 65536;
            e = longint'((r * r) >> 16);
            den = 65536 + d + e;
            if (den <= 0) den = 1;
            recip = (64'd1 << 48) / longint'(den);
            model_gain = clamp_range(longint'(recip >> (32 - FRAC)), 0, 33554432);
            model_fb1 = clamp_range(trunc_product(d + 2 * e, recip, 48 - FRAC),
                                    -67108864, 67108863);
            model_fb2 = clamp_range(trunc_product(-e, recip, 48 - FRAC), -33554432, 0);
            model_enabled = 1'b1;
            clear_out = w.clr;
        end
        o.enabled = model_enabled;
        o.gain = model_gain[25:0];
        o.fb1 = model_fb1[26:0];
        o.fb2 = model_fb2[25:0];
        o.clr_hist = clear_out;
        return o;
    endfunction

    function automatic voice_word_t random_word();
        voice_word_t w;
        w.cutoff = 8'($urandom_range(0, 255));
        w.resonance = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        w.modifier = 10'(int'($urandom_range(0, 512)) - 256);
        w.note = 1'($urandom_range(0, 1));
        w.clr = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // sender: offer the queue head, hold until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_coefs.push_back(predict_coefs(pending_words.pop_front()));
            end
            if ((!in_valid || in_ready) && pending_words.size() > 0 &&
                (sender_calm || $urandom_range(0, 99) >= 33))
            begin
                if (in_valid && in_ready && pending_words.size() == 0)
                    in_valid <= 1'b0;
                else
                begin
                    in_valid <= 1'b1;
                    cutoff_value <= pending_words[0].cutoff;
                    resonance_value <= pending_words[0].resonance;
                    envelope_modifier <= pending_words[0].modifier;
                    new_note <= pending_words[0].note;
                    clear_request <= pending_words[0].clr;
                end
            end
            else if (in_valid && in_ready)
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls plus a long hold-off; checks each accepted word
    always @(posedge clk or negedge rst_n)
    begin
        coef_word_t exp_w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_coefs.size() == 0)
                begin
                    $display("%0t: unexpected word enabled=%0d gain=%0d", $time,
                             filter_enabled, gain_coef);
                    error_count++;
                end
                else
                begin
                    exp_w = expected_coefs.pop_front();
                    if (filter_enabled !== exp_w.enabled)
                    begin
                        $display("%0t: filter_enabled exp %0d act %0d", $time,
                                 exp_w.enabled, filter_enabled);
                        error_count++;
                    end
                    if (gain_coef !== exp_w.gain)
                    begin
                        $display("%0t: gain_coef exp %0d act %0d", $time,
                                 exp_w.gain, gain_coef);
                        error_count++;
                    end
                    if (feedback_one !== exp_w.fb1)
                    begin
                        $display("%0t: feedback_one exp %0d act %0d", $time,
                                 exp_w.fb1, feedback_one);
                        error_count++;
                    end
                    if (feedback_two !== exp_w.fb2)
                    begin
                        $display("%0t: feedback_two exp %0d act %0d", $time,
                                 exp_w.fb2, feedback_two);
                        error_count++;
                    end
                    if (clear_history !== exp_w.clr_hist)
                    begin
                        $display("%0t: clear_history exp %0d act %0d", $time,
                                 exp_w.clr_hist, clear_history);
                        error_count++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= receiver_calm || ($urandom_range(0, 99) >= 33);
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_coefs.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_mix_rate(logic [17:0] rate);
        mix_rate_we <= 1'b1;
        mix_rate_data <= rate;
        @(posedge clk);
        mix_rate_we <= 1'b0;
        model_rate = rate;
    endtask

    initial
    begin
        voice_word_t w;
        logic [17:0] rates[6];
        rates = '{18'd8000, 18'd192000, 18'd0, 18'd262143, 18'd48000, 18'd22050};
        error_count = 0;
        sender_calm = 0;
        receiver_calm = 0;
        hold_cycles = 0;
        model_rate = MIX_RATE_RESET;
        model_enabled = 0;
        model_gain = 0;
        model_fb1 = 0;
        model_fb2 = 0;
        rst_n = 1'b0;
        mix_rate_we = 1'b0;
        mix_rate_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cutoff_value = '0;
        resonance_value = '0;
        envelope_modifier = '0;
        new_note = 1'b0;
        clear_request = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bypass before any active update, field extremes, saturation
        pending_words.push_back('{8'd255, 8'd0, 10'sd0, 1'b1, 1'b1});
        pending_words.push_back('{8'd0, 8'd0, -10'sd256, 1'b0, 1'b1});
        pending_words.push_back('{8'd255, 8'd255, 10'sd256, 1'b0, 1'b0});
        pending_words.push_back('{8'd254, 8'd0, 10'sd0, 1'b0, 1'b1});
        pending_words.push_back('{8'd254, 8'd0, 10'sd0, 1'b1, 1'b0});
        pending_words.push_back('{8'd127, 8'd127, 10'sd0, 1'b1, 1'b1});
        pending_words.push_back('{8'd127, 8'd128, 10'sd0, 1'b0, 1'b0});
        pending_words.push_back('{8'd200, 8'd0, -10'sd512, 1'b0, 1'b1});
        pending_words.push_back('{8'd200, 8'd0, 10'sd511, 1'b1, 1'b0});
        pending_words.push_back('{8'd128, 8'd0, 10'sd256, 1'b0, 1'b0});
        pending_words.push_back('{8'd1, 8'd1, -10'sd1, 1'b1, 1'b1});
        pending_words.push_back('{8'd253, 8'd0, 10'sd0, 1'b0, 1'b1});
        wait_drained();

        // long receiver hold-off while words keep coming
        sender_calm = 1;
        hold_cycles = 2000;
        for (int i = 0; i < 20; i++) pending_words.push_back(random_word());
        wait_drained();
        sender_calm = 0;

        // random phases across mix rates, one calm stretch
        for (int ph = 0; ph < 6; ph++)
        begin
            set_mix_rate(rates[ph]);
            sender_calm = (ph == 2);
            receiver_calm = (ph == 2);
            for (int i = 0; i < 80; i++)
            begin
                w = random_word();
                pending_words.push_back(w);
            end
            wait_drained();
        end
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
